>>> rtl/c2s_pkg.sv
// shared constants, types and angle table of the cartesian to spherical unit
`default_nettype none

package c2s_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned ITERATIONS_DEF  = 16;

  localparam int unsigned ANG_W       = 16;
  localparam int unsigned RAD_W       = 16;
  localparam int unsigned THR_W       = 15;
  localparam int unsigned ACC_W       = 25;
  localparam int unsigned ACC_FRAC    = 8;
  localparam int unsigned TABLE_LEN   = 24;
  localparam int unsigned FIXED_POINT = 30;
  localparam int          PITCH_LIM   = 16384;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(16383);

  localparam logic signed [ACC_W-1:0] QUARTER_ACC = ACC_W'(4194304);
  localparam logic signed [ACC_W-1:0] ROUND_ACC   = ACC_W'(1 << (ACC_FRAC - 1));

  typedef struct packed {
    logic s_nz;
    logic sxz_nz;
  } c2s_flags_t;

  // fraction bits added to the coordinates inside the rotation stages
  function automatic int unsigned frac_bits(input int unsigned w);
    return (w < FIXED_POINT) ? FIXED_POINT - w : 0;
  endfunction

  // atan(2^-i) in binary angle units with eight fraction bits
  function automatic int atan_entry(input int unsigned i);
    int v;
    unique case (i)
      0:       v = 2097152;
      1:       v = 1238021;
      2:       v = 654136;
      3:       v = 332050;
      4:       v = 166669;
      5:       v = 83416;
      6:       v = 41718;
      7:       v = 20860;
      8:       v = 10430;
      9:       v = 5215;
      10:      v = 2608;
      11:      v = 1304;
      12:      v = 652;
      13:      v = 326;
      14:      v = 163;
      15:      v = 81;
      16:      v = 41;
      17:      v = 20;
      18:      v = 10;
      19:      v = 5;
      20:      v = 3;
      21:      v = 1;
      22:      v = 1;
      default: v = 0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/c2s_intf.sv
// valid/ready channel interfaces for vectors in and spherical results out
`default_nettype none

interface c2s_in_if #(
  parameter int unsigned W = c2s_pkg::COORD_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] x_coord;
  logic signed [W-1:0] y_coord;
  logic signed [W-1:0] z_coord;

  modport source (output valid, x_coord, y_coord, z_coord, input ready);
  modport sink   (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

interface c2s_out_if ();
  import c2s_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [RAD_W-1:0]        radius;
  logic signed [ANG_W-1:0] yaw_angle;
  logic signed [ANG_W-1:0] pitch_angle;

  modport source (output valid, radius, yaw_angle, pitch_angle, input ready);
  modport sink   (input valid, radius, yaw_angle, pitch_angle, output ready);
endinterface

`default_nettype wire

>>> rtl/c2s_prep.sv
// input stages: squares, sums, yaw pre-rotation and zero flags
`default_nettype none

module c2s_prep #(
  parameter int unsigned W = c2s_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  output logic                                    ready_o,
  input  wire logic signed [W-1:0]                x_i,
  input  wire logic signed [W-1:0]                y_i,
  input  wire logic signed [W-1:0]                z_i,
  output logic                                    valid_o,
  input  wire logic                               ready_i,
  output logic [2*W-1:0]                          s_o,
  output logic [2*W-1:0]                          sxz_o,
  output logic signed [W:0]                       ny_o,
  output logic signed [W+c2s_pkg::frac_bits(W)+2:0] ya_o,
  output logic signed [W+c2s_pkg::frac_bits(W)+2:0] yb_o,
  output logic signed [c2s_pkg::ACC_W-1:0]        yacc_o,
  output c2s_pkg::c2s_flags_t                     flags_o
);
  import c2s_pkg::*;

  localparam int unsigned F  = frac_bits(W);
  localparam int unsigned AW = W + F + 3;

  logic                      valid1_q, valid2_q;
  logic                      ready1, ready2;
  logic signed [2*W-1:0]     xx, yy, zz;
  logic [2*W-1:0]            xx1_q, yy1_q, zz1_q;
  logic signed [W:0]         ny1_d, ny1_q, ny2_q;
  logic signed [AW-1:0]      za, xb;
  logic signed [AW-1:0]      ya1_d, yb1_d, ya1_q, yb1_q, ya2_q, yb2_q;
  logic signed [ACC_W-1:0]   yacc1_d, yacc1_q, yacc2_q;
  c2s_flags_t                flags1_d, flags1_q, flags2_q;
  logic [2*W-1:0]            sxz2_d, s2_d, sxz2_q, s2_q;

  assign ready1  = !valid1_q || ready2;
  assign ready2  = !valid2_q || ready_i;
  assign ready_o = ready1;

  assign xx = x_i * x_i;
  assign yy = y_i * y_i;
  assign zz = z_i * z_i;

  assign ny1_d = -((W+1)'(y_i));
  assign za    = AW'(z_i) <<< F;
  assign xb    = AW'(x_i) <<< F;

  assign flags1_d.s_nz   = (x_i != '0) || (y_i != '0) || (z_i != '0);
  assign flags1_d.sxz_nz = (x_i != '0) || (z_i != '0);

  // turn the yaw vector a quarter turn into the right half plane
  always_comb begin
    if (za[AW-1]) begin
      if (!xb[AW-1]) begin
        ya1_d   = xb;
        yb1_d   = -za;
        yacc1_d = QUARTER_ACC;
      end else begin
        ya1_d   = -xb;
        yb1_d   = za;
        yacc1_d = -QUARTER_ACC;
      end
    end else begin
      ya1_d   = za;
      yb1_d   = xb;
      yacc1_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      if (ready1) begin
        valid1_q <= valid_i;
      end
      if (ready2) begin
        valid2_q <= valid1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && valid_i) begin
      xx1_q    <= xx;
      yy1_q    <= yy;
      zz1_q    <= zz;
      ny1_q    <= ny1_d;
      ya1_q    <= ya1_d;
      yb1_q    <= yb1_d;
      yacc1_q  <= yacc1_d;
      flags1_q <= flags1_d;
    end
  end

  assign sxz2_d = xx1_q + zz1_q;
  assign s2_d   = sxz2_d + yy1_q;

  always_ff @(posedge clk_i) begin
    if (ready2 && valid1_q) begin
      sxz2_q   <= sxz2_d;
      s2_q     <= s2_d;
      ny2_q    <= ny1_q;
      ya2_q    <= ya1_q;
      yb2_q    <= yb1_q;
      yacc2_q  <= yacc1_q;
      flags2_q <= flags1_q;
    end
  end

  assign valid_o = valid2_q;
  assign s_o     = s2_q;
  assign sxz_o   = sxz2_q;
  assign ny_o    = ny2_q;
  assign ya_o    = ya2_q;
  assign yb_o    = yb2_q;
  assign yacc_o  = yacc2_q;
  assign flags_o = flags2_q;

endmodule

`default_nettype wire

>>> rtl/c2s_front_cell.sv
// front cell: hypot(x,z) root digit, radius digit if K<W, yaw rotation if K<IT
`default_nettype none

module c2s_front_cell #(
  parameter int unsigned W  = c2s_pkg::COORD_WIDTH_DEF,
  parameter int unsigned IT = c2s_pkg::ITERATIONS_DEF,
  parameter int unsigned K  = 0
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  valid_i,
  output logic                                       ready_o,
  input  wire logic [2*W-1:0]                        h_opnd_i,
  input  wire logic [W+c2s_pkg::frac_bits(W)+1:0]    h_rem_i,
  input  wire logic [W+c2s_pkg::frac_bits(W)-1:0]    h_root_i,
  input  wire logic [2*W-1:0]                        r_opnd_i,
  input  wire logic [W+1:0]                          r_rem_i,
  input  wire logic [W-1:0]                          r_root_i,
  input  wire logic signed [W+c2s_pkg::frac_bits(W)+2:0] ya_i,
  input  wire logic signed [W+c2s_pkg::frac_bits(W)+2:0] yb_i,
  input  wire logic signed [c2s_pkg::ACC_W-1:0]     yacc_i,
  input  wire logic signed [W:0]                     ny_i,
  input  wire c2s_pkg::c2s_flags_t                   flags_i,
  output logic                                       valid_o,
  input  wire logic                                  ready_i,
  output logic [2*W-1:0]                             h_opnd_o,
  output logic [W+c2s_pkg::frac_bits(W)+1:0]         h_rem_o,
  output logic [W+c2s_pkg::frac_bits(W)-1:0]         h_root_o,
  output logic [2*W-1:0]                             r_opnd_o,
  output logic [W+1:0]                               r_rem_o,
  output logic [W-1:0]                               r_root_o,
  output logic signed [W+c2s_pkg::frac_bits(W)+2:0]  ya_o,
  output logic signed [W+c2s_pkg::frac_bits(W)+2:0]  yb_o,
  output logic signed [c2s_pkg::ACC_W-1:0]          yacc_o,
  output logic signed [W:0]                          ny_o,
  output c2s_pkg::c2s_flags_t                        flags_o
);
  import c2s_pkg::*;

  localparam int unsigned F   = frac_bits(W);
  localparam int unsigned NH  = W + F;
  localparam int unsigned AW  = NH + 3;
  localparam int unsigned HRW = NH + 2;
  localparam int unsigned RRW = W + 2;

  logic                    valid_q;
  logic [2*W-1:0]          h_opnd_d, h_opnd_q, r_opnd_d, r_opnd_q;
  logic [HRW-1:0]          h_rem_d, h_rem_q;
  logic [NH-1:0]           h_root_d, h_root_q;
  logic [RRW-1:0]          r_rem_d, r_rem_q;
  logic [W-1:0]            r_root_d, r_root_q;
  logic signed [AW-1:0]    ya_d, yb_d, ya_q, yb_q;
  logic signed [ACC_W-1:0] yacc_d, yacc_q;
  logic signed [W:0]       ny_q;
  c2s_flags_t              flags_q;

  logic [HRW+1:0]          h_sh, h_trial;
  logic                    h_ge;

  assign ready_o = !valid_q || ready_i;

  // restoring square root digit of hypot(x,z) scaled by 2^F
  assign h_sh     = {h_rem_i, h_opnd_i[2*W-1 -: 2]};
  assign h_trial  = (HRW+2)'({h_root_i, 2'b01});
  assign h_ge     = h_sh >= h_trial;
  assign h_rem_d  = h_ge ? HRW'(h_sh - h_trial) : HRW'(h_sh);
  assign h_root_d = {h_root_i[NH-2:0], h_ge};
  assign h_opnd_d = h_opnd_i << 2;

  if (K < W) begin : g_rad
    logic [RRW+1:0] r_sh, r_trial;
    logic           r_ge;

    assign r_sh     = {r_rem_i, r_opnd_i[2*W-1 -: 2]};
    assign r_trial  = (RRW+2)'({r_root_i, 2'b01});
    assign r_ge     = r_sh >= r_trial;
    assign r_rem_d  = r_ge ? RRW'(r_sh - r_trial) : RRW'(r_sh);
    assign r_root_d = {r_root_i[W-2:0], r_ge};
    assign r_opnd_d = r_opnd_i << 2;
  end else begin : g_rad_done
    assign r_rem_d  = r_rem_i;
    assign r_root_d = r_root_i;
    assign r_opnd_d = r_opnd_i;
  end

  if ((K < IT) && (K < TABLE_LEN)) begin : g_yaw
    localparam logic signed [ACC_W-1:0] ANG = ACC_W'(atan_entry(K));
    logic signed [AW-1:0] da, db;

    assign da = yb_i >>> K;
    assign db = ya_i >>> K;

    always_comb begin
      if (!yb_i[AW-1]) begin
        ya_d   = ya_i + da;
        yb_d   = yb_i - db;
        yacc_d = yacc_i + ANG;
      end else begin
        ya_d   = ya_i - da;
        yb_d   = yb_i + db;
        yacc_d = yacc_i - ANG;
      end
    end
  end else begin : g_yaw_done
    assign ya_d   = ya_i;
    assign yb_d   = yb_i;
    assign yacc_d = yacc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      h_opnd_q <= h_opnd_d;
      h_rem_q  <= h_rem_d;
      h_root_q <= h_root_d;
      r_opnd_q <= r_opnd_d;
      r_rem_q  <= r_rem_d;
      r_root_q <= r_root_d;
      ya_q     <= ya_d;
      yb_q     <= yb_d;
      yacc_q   <= yacc_d;
      ny_q     <= ny_i;
      flags_q  <= flags_i;
    end
  end

  assign valid_o  = valid_q;
  assign h_opnd_o = h_opnd_q;
  assign h_rem_o  = h_rem_q;
  assign h_root_o = h_root_q;
  assign r_opnd_o = r_opnd_q;
  assign r_rem_o  = r_rem_q;
  assign r_root_o = r_root_q;
  assign ya_o     = ya_q;
  assign yb_o     = yb_q;
  assign yacc_o   = yacc_q;
  assign ny_o     = ny_q;
  assign flags_o  = flags_q;

endmodule

`default_nettype wire

>>> rtl/c2s_pitch_cell.sv
// pitch cell: one vectoring rotation of (hypot(x,z), -y)
`default_nettype none

module c2s_pitch_cell #(
  parameter int unsigned W = c2s_pkg::COORD_WIDTH_DEF,
  parameter int unsigned K = 0
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      valid_i,
  output logic                                           ready_o,
  input  wire logic signed [W+c2s_pkg::frac_bits(W)+2:0] pa_i,
  input  wire logic signed [W+c2s_pkg::frac_bits(W)+2:0] pb_i,
  input  wire logic signed [c2s_pkg::ACC_W-1:0]         pacc_i,
  input  wire logic [c2s_pkg::RAD_W-1:0]                 radius_i,
  input  wire logic signed [c2s_pkg::ANG_W-1:0]         yaw_i,
  input  wire c2s_pkg::c2s_flags_t                       flags_i,
  output logic                                           valid_o,
  input  wire logic                                      ready_i,
  output logic signed [W+c2s_pkg::frac_bits(W)+2:0]      pa_o,
  output logic signed [W+c2s_pkg::frac_bits(W)+2:0]      pb_o,
  output logic signed [c2s_pkg::ACC_W-1:0]              pacc_o,
  output logic [c2s_pkg::RAD_W-1:0]                      radius_o,
  output logic signed [c2s_pkg::ANG_W-1:0]              yaw_o,
  output c2s_pkg::c2s_flags_t                            flags_o
);
  import c2s_pkg::*;

  localparam int unsigned AW = W + frac_bits(W) + 3;
  localparam logic signed [ACC_W-1:0] ANG = ACC_W'(atan_entry(K));

  logic                    valid_q;
  logic signed [AW-1:0]    da, db, pa_d, pb_d, pa_q, pb_q;
  logic signed [ACC_W-1:0] pacc_d, pacc_q;
  logic [RAD_W-1:0]        radius_q;
  logic signed [ANG_W-1:0] yaw_q;
  c2s_flags_t              flags_q;

  assign ready_o = !valid_q || ready_i;

  assign da = pb_i >>> K;
  assign db = pa_i >>> K;

  always_comb begin
    if (!pb_i[AW-1]) begin
      pa_d   = pa_i + da;
      pb_d   = pb_i - db;
      pacc_d = pacc_i + ANG;
    end else begin
      pa_d   = pa_i - da;
      pb_d   = pb_i + db;
      pacc_d = pacc_i - ANG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pa_q     <= pa_d;
      pb_q     <= pb_d;
      pacc_q   <= pacc_d;
      radius_q <= radius_i;
      yaw_q    <= yaw_i;
      flags_q  <= flags_i;
    end
  end

  assign valid_o  = valid_q;
  assign pa_o     = pa_q;
  assign pb_o     = pb_q;
  assign pacc_o   = pacc_q;
  assign radius_o = radius_q;
  assign yaw_o    = yaw_q;
  assign flags_o  = flags_q;

endmodule

`default_nettype wire

>>> rtl/c2s_result.sv
// result stages: pitch rounding and clamp, pole test, output register
`default_nettype none

module c2s_result (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  output logic                                   ready_o,
  input  wire logic signed [c2s_pkg::ACC_W-1:0] pacc_i,
  input  wire logic [c2s_pkg::RAD_W-1:0]         radius_i,
  input  wire logic signed [c2s_pkg::ANG_W-1:0] yaw_i,
  input  wire c2s_pkg::c2s_flags_t               flags_i,
  input  wire logic [c2s_pkg::THR_W-1:0]         thr_i,
  output logic                                   valid_o,
  input  wire logic                              ready_i,
  output logic [c2s_pkg::RAD_W-1:0]              radius_o,
  output logic signed [c2s_pkg::ANG_W-1:0]      yaw_o,
  output logic signed [c2s_pkg::ANG_W-1:0]      pitch_o
);
  import c2s_pkg::*;

  localparam int unsigned CW = ACC_W - ACC_FRAC;
  localparam logic signed [CW-1:0] P_MAX = CW'(PITCH_LIM);
  localparam logic signed [CW-1:0] P_MIN = -P_MAX;

  logic                    va_q, vb_q;
  logic                    ready_a, ready_b;
  logic signed [ACC_W-1:0] prnd;
  logic signed [CW-1:0]    pcoarse;
  logic signed [ANG_W-1:0] pclamp, pa_q;
  logic [RAD_W-1:0]        ra_q, radius_q;
  logic signed [ANG_W-1:0] ya_q, yaw_q, pitch_q;
  c2s_flags_t              fa_q;
  logic signed [ANG_W-1:0] mag;
  logic                    keep_yaw;

  assign ready_a = !va_q || ready_b;
  assign ready_b = !vb_q || ready_i;
  assign ready_o = ready_a;

  assign prnd    = pacc_i + ROUND_ACC;
  assign pcoarse = prnd[ACC_W-1:ACC_FRAC];

  always_comb begin
    priority if (pcoarse > P_MAX) begin
      pclamp = ANG_W'(P_MAX);
    end else if (pcoarse < P_MIN) begin
      pclamp = ANG_W'(P_MIN);
    end else begin
      pclamp = ANG_W'(pcoarse);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) begin
        va_q <= valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      pa_q <= pclamp;
      ra_q <= radius_i;
      ya_q <= yaw_i;
      fa_q <= flags_i;
    end
  end

  // yaw is dropped near the poles and when x and z are both zero
  assign mag      = pa_q[ANG_W-1] ? -pa_q : pa_q;
  assign keep_yaw = fa_q.sxz_nz && (unsigned'(mag) < ANG_W'(thr_i));

  always_ff @(posedge clk_i) begin
    if (ready_b && va_q) begin
      radius_q <= fa_q.s_nz ? ra_q : '0;
      yaw_q    <= (fa_q.s_nz && keep_yaw) ? ya_q : '0;
      pitch_q  <= fa_q.s_nz ? pa_q : '0;
    end
  end

  assign valid_o  = vb_q;
  assign radius_o = radius_q;
  assign yaw_o    = yaw_q;
  assign pitch_o  = pitch_q;

endmodule

`default_nettype wire

>>> rtl/cartesian_to_spherical_unit.sv
// top level of the cartesian to spherical converter
// stages: prep, front cells, pitch cells, result; front cells form the root digits,
// in-range cells rotate; F = 30 - COORD_WIDTH below 30, else 0, hypot fraction bits
// throughput: one vector per cycle unless the output stalls; every cell holds its item
// in its own register and takes a new one whenever the next cell moves on or it is empty
// reset empties all cells and sets the pole threshold thr_q to 16383
`default_nettype none

module cartesian_to_spherical_unit #(
  parameter int unsigned ITERATIONS  = c2s_pkg::ITERATIONS_DEF,
  parameter int unsigned COORD_WIDTH = c2s_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [c2s_pkg::THR_W-1:0]  cfg_wdata_i,
  c2s_in_if.sink                          in_ch,
  c2s_out_if.source                       out_ch
);
  import c2s_pkg::*;

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned F   = frac_bits(W);
  localparam int unsigned NH  = W + F;
  localparam int unsigned AW  = NH + 3;
  localparam int unsigned HRW = NH + 2;
  localparam int unsigned RRW = W + 2;
  localparam int unsigned IT  = ITERATIONS;

  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // front chain
  logic                    f_valid [NH+1];
  logic                    f_ready [NH+1];
  logic [2*W-1:0]          f_hop   [NH+1];
  logic [HRW-1:0]          f_hrem  [NH+1];
  logic [NH-1:0]           f_hroot [NH+1];
  logic [2*W-1:0]          f_rop   [NH+1];
  logic [RRW-1:0]          f_rrem  [NH+1];
  logic [W-1:0]            f_rroot [NH+1];
  logic signed [AW-1:0]    f_ya    [NH+1];
  logic signed [AW-1:0]    f_yb    [NH+1];
  logic signed [ACC_W-1:0] f_yacc  [NH+1];
  logic signed [W:0]       f_ny    [NH+1];
  c2s_flags_t              f_flags [NH+1];

  assign f_hrem[0]  = '0;
  assign f_hroot[0] = '0;
  assign f_rrem[0]  = '0;
  assign f_rroot[0] = '0;

  c2s_prep #(
    .W (W)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_ch.valid),
    .ready_o (in_ch.ready),
    .x_i     (in_ch.x_coord),
    .y_i     (in_ch.y_coord),
    .z_i     (in_ch.z_coord),
    .valid_o (f_valid[0]),
    .ready_i (f_ready[0]),
    .s_o     (f_rop[0]),
    .sxz_o   (f_hop[0]),
    .ny_o    (f_ny[0]),
    .ya_o    (f_ya[0]),
    .yb_o    (f_yb[0]),
    .yacc_o  (f_yacc[0]),
    .flags_o (f_flags[0])
  );

  for (genvar k = 0; k < NH; k++) begin : g_front
    c2s_front_cell #(
      .W  (W),
      .IT (IT),
      .K  (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (f_valid[k]),
      .ready_o  (f_ready[k]),
      .h_opnd_i (f_hop[k]),
      .h_rem_i  (f_hrem[k]),
      .h_root_i (f_hroot[k]),
      .r_opnd_i (f_rop[k]),
      .r_rem_i  (f_rrem[k]),
      .r_root_i (f_rroot[k]),
      .ya_i     (f_ya[k]),
      .yb_i     (f_yb[k]),
      .yacc_i   (f_yacc[k]),
      .ny_i     (f_ny[k]),
      .flags_i  (f_flags[k]),
      .valid_o  (f_valid[k+1]),
      .ready_i  (f_ready[k+1]),
      .h_opnd_o (f_hop[k+1]),
      .h_rem_o  (f_hrem[k+1]),
      .h_root_o (f_hroot[k+1]),
      .r_opnd_o (f_rop[k+1]),
      .r_rem_o  (f_rrem[k+1]),
      .r_root_o (f_rroot[k+1]),
      .ya_o     (f_ya[k+1]),
      .yb_o     (f_yb[k+1]),
      .yacc_o   (f_yacc[k+1]),
      .ny_o     (f_ny[k+1]),
      .flags_o  (f_flags[k+1])
    );
  end

  // radius rounding, yaw rounding and pitch vector set-up
  logic                    rad_up;
  logic [W-1:0]            rad_full;
  logic [W+RAD_W-1:0]      rad_ext;
  logic signed [ACC_W-1:0] yrnd;

  assign rad_up   = RRW'(f_rroot[NH]) < f_rrem[NH];
  assign rad_full = f_rroot[NH] + W'(rad_up);
  assign rad_ext  = (W+RAD_W)'(rad_full);
  assign yrnd     = f_yacc[NH] + ROUND_ACC;

  // pitch chain
  logic                    p_valid  [IT+1];
  logic                    p_ready  [IT+1];
  logic signed [AW-1:0]    p_a      [IT+1];
  logic signed [AW-1:0]    p_b      [IT+1];
  logic signed [ACC_W-1:0] p_acc    [IT+1];
  logic [RAD_W-1:0]        p_radius [IT+1];
  logic signed [ANG_W-1:0] p_yaw    [IT+1];
  c2s_flags_t              p_flags  [IT+1];

  assign p_valid[0]  = f_valid[NH];
  assign f_ready[NH] = p_ready[0];
  assign p_a[0]      = signed'(AW'(f_hroot[NH]));
  assign p_b[0]      = AW'(f_ny[NH]) <<< F;
  assign p_acc[0]    = '0;
  assign p_radius[0] = rad_ext[RAD_W-1:0];
  assign p_yaw[0]    = yrnd[ACC_FRAC +: ANG_W];
  assign p_flags[0]  = f_flags[NH];

  for (genvar k = 0; k < IT; k++) begin : g_pitch
    c2s_pitch_cell #(
      .W (W),
      .K (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (p_valid[k]),
      .ready_o  (p_ready[k]),
      .pa_i     (p_a[k]),
      .pb_i     (p_b[k]),
      .pacc_i   (p_acc[k]),
      .radius_i (p_radius[k]),
      .yaw_i    (p_yaw[k]),
      .flags_i  (p_flags[k]),
      .valid_o  (p_valid[k+1]),
      .ready_i  (p_ready[k+1]),
      .pa_o     (p_a[k+1]),
      .pb_o     (p_b[k+1]),
      .pacc_o   (p_acc[k+1]),
      .radius_o (p_radius[k+1]),
      .yaw_o    (p_yaw[k+1]),
      .flags_o  (p_flags[k+1])
    );
  end

  c2s_result u_result (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (p_valid[IT]),
    .ready_o  (p_ready[IT]),
    .pacc_i   (p_acc[IT]),
    .radius_i (p_radius[IT]),
    .yaw_i    (p_yaw[IT]),
    .flags_i  (p_flags[IT]),
    .thr_i    (thr_q),
    .valid_o  (out_ch.valid),
    .ready_i  (out_ch.ready),
    .radius_o (out_ch.radius),
    .yaw_o    (out_ch.yaw_angle),
    .pitch_o  (out_ch.pitch_angle)
  );

endmodule

`default_nettype wire

>>> tb/spherical_result_checker.sv
// checker that predicts the spherical form of every accepted vector and compares results
`timescale 1ns / 1ps

module spherical_result_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [c2s_pkg::THR_W-1:0] cfg_wdata_i,
  c2s_in_if                         in_ch,
  c2s_out_if                        out_ch,
  output int unsigned               mismatches_o,
  output int unsigned               pending_o
);
  import c2s_pkg::*;

  localparam int unsigned FRAC         = 14;
  localparam int unsigned STAGES       = 16;
  localparam longint      FRAC_SCALE   = 64'sd1 <<< FRAC;
  localparam longint      QUARTER_TURN = 64'sd4194304;
  localparam longint      HALF_LSB     = 64'sd128;
  localparam longint      POLE_PITCH   = 64'sd16384;
  localparam int unsigned REPORT_MAX   = 10;

  // atan(2^-i) in binary angle units, eight fraction bits
  localparam longint ATAN_STEP [STAGES] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic [RAD_W-1:0]        radius;
    logic signed [ANG_W-1:0] yaw;
    logic signed [ANG_W-1:0] pitch;
  } spherical_t;

  spherical_t       queued_spherical [$];
  spherical_t       got;
  spherical_t       want;
  logic [THR_W-1:0] pole_thr;
  int unsigned      mismatch_cnt;
  int unsigned      result_idx;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // atan2(b, a) by vectoring rotations, rounded and wrapped to a binary angle
  function automatic logic signed [ANG_W-1:0] binang_atan2(longint b, longint a);
    longint acc;
    longint t;
    longint da;
    longint db;
    int     i;
    acc = 0;
    if (a < 0) begin
      if (b >= 0) begin
        t = a; a = b; b = -t; acc = QUARTER_TURN;
      end else begin
        t = a; a = -b; b = t; acc = -QUARTER_TURN;
      end
    end
    for (i = 0; i < STAGES; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a += da; b -= db; acc += ATAN_STEP[i];
      end else begin
        a -= da; b += db; acc -= ATAN_STEP[i];
      end
    end
    acc = (acc + HALF_LSB) >>> 8;
    return acc[ANG_W-1:0];
  endfunction

  function automatic spherical_t to_spherical(logic signed [15:0] x, logic signed [15:0] y,
                                              logic signed [15:0] z, logic [THR_W-1:0] thr);
    longint          xs;
    longint          ys;
    longint          zs;
    longint          pitch;
    longint          yaw;
    longint          mag;
    longint unsigned sxz;
    longint unsigned s;
    longint unsigned r;
    longint unsigned hxz;
    spherical_t      res;
    xs    = x;
    ys    = y;
    zs    = z;
    sxz   = xs * xs + zs * zs;
    s     = sxz + longint'(ys * ys);
    r     = int_sqrt(s);
    yaw   = 0;
    pitch = 0;
    if (s - r * r > r) r++;
    if (s != 0) begin
      hxz   = int_sqrt(sxz << (2 * FRAC));
      pitch = binang_atan2(-ys * FRAC_SCALE, longint'(hxz));
      if (pitch > POLE_PITCH) pitch = POLE_PITCH;
      if (pitch < -POLE_PITCH) pitch = -POLE_PITCH;
      mag = (pitch < 0) ? -pitch : pitch;
      if (sxz != 0 && mag < longint'(thr)) begin
        yaw = binang_atan2(xs * FRAC_SCALE, zs * FRAC_SCALE);
      end
    end else begin
      r = 0;
    end
    res.radius = r[RAD_W-1:0];
    res.yaw    = yaw[ANG_W-1:0];
    res.pitch  = pitch[ANG_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_spherical.delete();
      pole_thr     <= 15'd16383;
      mismatch_cnt  = 0;
      result_idx    = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.radius = out_ch.radius;
        got.yaw    = out_ch.yaw_angle;
        got.pitch  = out_ch.pitch_angle;
        if (queued_spherical.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("result %0d: none pending, got radius %0d yaw %0d pitch %0d",
                     result_idx, got.radius, got.yaw, got.pitch);
          end
        end else begin
          want = queued_spherical.pop_front();
          if (got.radius != want.radius || got.yaw != want.yaw || got.pitch != want.pitch) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX) begin
              $display("result %0d: expected radius %0d yaw %0d pitch %0d, got %0d %0d %0d",
                       result_idx, want.radius, want.yaw, want.pitch,
                       got.radius, got.yaw, got.pitch);
            end
          end
        end
        result_idx++;
      end
      if (in_ch.valid && in_ch.ready) begin
        queued_spherical.push_back(to_spherical(in_ch.x_coord, in_ch.y_coord,
                                                in_ch.z_coord, pole_thr));
      end
      if (cfg_we_i) pole_thr <= cfg_wdata_i;
      mismatches_o <= mismatch_cnt;
      pending_o    <= queued_spherical.size();
    end
  end

endmodule

>>> tb/testbench.sv
// stimulus, handshake pacing and verdict for the cartesian to spherical unit
`timescale 1ns / 1ps

module testbench;
  import c2s_pkg::*;

  localparam int unsigned PHASE_ITEMS = 158;
  localparam int unsigned IDLE_LIMIT  = 1000;
  localparam int unsigned TAIL_CYCLES = 100;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [THR_W-1:0] cfg_wdata;
  logic             in_steady;
  logic             out_steady;
  int unsigned      mismatches;
  int unsigned      pending;

  c2s_in_if #(.W(16)) in_ch ();
  c2s_out_if          out_ch ();

  cartesian_to_spherical_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  spherical_result_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_vec(input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic signed [15:0] z);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.x_coord <= x;
    in_ch.y_coord <= y;
    in_ch.z_coord <= z;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold the sender until every queued vector has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_coord(input int mode);
    logic signed [15:0] corners [6];
    corners = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    case (mode)
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 16)) - 16'sd8;
      2:       return corners[$urandom_range(0, 5)];
      default: return 16'($urandom_range(0, 6)) - 16'sd3;
    endcase
  endfunction

  task automatic send_random(input int unsigned count);
    int                 kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        in_steady  = ($urandom_range(0, 3) == 0);
        out_steady = ($urandom_range(0, 3) == 0);
      end
      kind = $urandom_range(0, 9);
      case (kind)
        5: begin x = pick_coord(1); y = pick_coord(1); z = pick_coord(1); end
        6: begin x = pick_coord(2); y = pick_coord(2); z = pick_coord(2); end
        7: begin x = pick_coord(3); y = pick_coord(0); z = pick_coord(3); end
        8: begin
          x = pick_coord(0); y = pick_coord(0); z = pick_coord(0);
          if ($urandom_range(0, 1) == 0) x = 16'sd0;
          else z = 16'sd0;
        end
        9: begin
          x = pick_coord($urandom_range(0, 3));
          y = pick_coord($urandom_range(0, 3));
          z = pick_coord($urandom_range(0, 3));
        end
        default: begin x = pick_coord(0); y = pick_coord(0); z = pick_coord(0); end
      endcase
      send_vec(x, y, z);
    end
  endtask

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("cartesian_to_spherical_unit: mismatch");
    $finish;
  end

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    logic [THR_W-1:0] thresholds [6];
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.x_coord <= '0;
    in_ch.y_coord <= '0;
    in_ch.z_coord <= '0;
    in_steady      = 1'b0;
    out_steady     = 1'b0;
    thresholds     = '{15'd0, 15'd16384, 15'd1, 15'($urandom_range(2, 16382)),
                       15'd12000, 15'd16383};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero vector, extremes, poles and the yaw wrap near minus z
    send_vec(16'sd0, 16'sd0, 16'sd0);
    send_vec(16'sd32767, 16'sd32767, 16'sd32767);
    send_vec(-16'sd32768, -16'sd32768, -16'sd32768);
    send_vec(16'sd0, 16'sd32767, 16'sd0);
    send_vec(16'sd0, -16'sd32768, 16'sd0);
    send_vec(16'sd0, 16'sd1, 16'sd0);
    send_vec(16'sd0, -16'sd1, 16'sd0);
    send_vec(16'sd0, 16'sd0, 16'sd1);
    send_vec(16'sd0, 16'sd0, -16'sd1);
    send_vec(16'sd1, 16'sd0, 16'sd0);
    send_vec(-16'sd1, 16'sd0, 16'sd0);
    send_vec(16'sd0, 16'sd0, -16'sd32768);
    send_vec(-16'sd32768, 16'sd0, 16'sd0);
    send_vec(16'sd32767, 16'sd0, -16'sd32768);
    send_vec(-16'sd32768, 16'sd0, -16'sd1);
    send_vec(16'sd1, 16'sd32767, 16'sd1);
    send_vec(16'sd1, -16'sd32768, 16'sd0);
    send_vec(16'sd32767, -16'sd32768, 16'sd32767);
    send_vec(-16'sd32768, 16'sd32767, 16'sd32767);
    send_vec(16'sd5, -16'sd3, -16'sd7);
    send_vec(16'sd100, 16'sd200, -16'sd300);
    send_vec(-16'sd1, -16'sd1, -16'sd1);

    foreach (thresholds[p]) begin
      drain_results();
      write_threshold(thresholds[p]);
      send_random(PHASE_ITEMS);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("cartesian_to_spherical_unit: match");
    end else begin
      $display("cartesian_to_spherical_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/c2s_pkg.sv
rtl/c2s_intf.sv
rtl/c2s_prep.sv
rtl/c2s_front_cell.sv
rtl/c2s_pitch_cell.sv
rtl/c2s_result.sv
rtl/cartesian_to_spherical_unit.sv
tb/spherical_result_checker.sv
tb/testbench.sv
